FILE: rtl/tod_pkg.sv
`timescale 1ns / 1ps
package tod_pkg;

   localparam int unsigned HOUR_W  = 5;
   localparam int unsigned MINSEC_W = 6;
   localparam int unsigned TOTAL_W = 17;
   localparam int unsigned MODE_W  = 3;

   localparam logic [HOUR_W-1:0]   MAX_HOUR       = 5'd23;
   localparam logic [MINSEC_W-1:0] MAX_MINSEC     = 6'd59;
   localparam logic [6:0]          MINSEC_MOD     = 7'd60;
   localparam logic [5:0]          HOUR_MOD       = 6'd24;
   localparam logic [TOTAL_W-1:0]  SECS_PER_HOUR  = 17'd3600;
   localparam logic [TOTAL_W-1:0]  SECS_PER_MIN   = 17'd60;

   localparam logic [MODE_W-1:0] MODE_HOLD      = 3'd0;
   localparam logic [MODE_W-1:0] MODE_LOAD      = 3'd1;
   localparam logic [MODE_W-1:0] MODE_TICK_UP   = 3'd2;
   localparam logic [MODE_W-1:0] MODE_TICK_DOWN = 3'd3;
   localparam logic [MODE_W-1:0] MODE_ADD       = 3'd4;
   localparam logic [MODE_W-1:0] MODE_SUB       = 3'd5;

   typedef logic [MODE_W-1:0] mode_type;

   typedef struct packed {
      logic [HOUR_W-1:0]   hours;
      logic [MINSEC_W-1:0] minutes;
      logic [MINSEC_W-1:0] seconds;
   } hms_type;

   typedef struct packed {
      logic     valid;
      mode_type mode;
      hms_type  operand;
   } stage_type;

   typedef struct packed {
      hms_type              cur;
      logic [TOTAL_W-1:0]   total;
      logic                 is_less;
      logic                 is_equal;
      hms_type              gap;
   } result_type;

   localparam hms_type ONE_SECOND = '{hours: 5'd0, minutes: 6'd0, seconds: 6'd1};

   function automatic hms_type hms_add(hms_type a, hms_type b);
      logic [6:0] s_sum;
      logic [6:0] m_sum;
      logic [5:0] h_sum;
      logic       cs;
      logic       cm;
      hms_type    r;
      s_sum     = {1'b0, a.seconds} + {1'b0, b.seconds};
      cs        = (s_sum >= MINSEC_MOD);
      r.seconds = cs ? 6'(s_sum - MINSEC_MOD) : s_sum[5:0];
      m_sum     = {1'b0, a.minutes} + {1'b0, b.minutes} + {6'd0, cs};
      cm        = (m_sum >= MINSEC_MOD);
      r.minutes = cm ? 6'(m_sum - MINSEC_MOD) : m_sum[5:0];
      h_sum     = {1'b0, a.hours} + {1'b0, b.hours} + {5'd0, cm};
      r.hours   = (h_sum >= HOUR_MOD) ? 5'(h_sum - HOUR_MOD) : h_sum[4:0];
      return r;
   endfunction

   function automatic hms_type hms_sub(hms_type a, hms_type b);
      logic [6:0] s_dif;
      logic [6:0] m_dif;
      logic [5:0] h_dif;
      hms_type    r;
      s_dif     = {1'b0, a.seconds} - {1'b0, b.seconds};
      r.seconds = s_dif[6] ? 6'(s_dif + MINSEC_MOD) : s_dif[5:0];
      m_dif     = {1'b0, a.minutes} - {1'b0, b.minutes} - {6'd0, s_dif[6]};
      r.minutes = m_dif[6] ? 6'(m_dif + MINSEC_MOD) : m_dif[5:0];
      h_dif     = {1'b0, a.hours} - {1'b0, b.hours} - {5'd0, m_dif[6]};
      r.hours   = h_dif[5] ? 5'(h_dif + HOUR_MOD) : h_dif[4:0];
      return r;
   endfunction

endpackage

FILE: rtl/tod_req_stage.sv
`timescale 1ns / 1ps
module tod_req_stage import tod_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_tvalid,
   output logic            req_tready,
   input  logic [2:0]      req_tuser,   // mode
   input  logic [23:0]     req_tdata,   // op_hours, op_minutes, op_seconds, zero fill
   input  logic            advance,
   output stage_type       stage
);

   logic     valid_ff, valid_in;
   mode_type mode_ff;
   hms_type  op_ff, op_in;
   logic     take;

   assign req_tready = !valid_ff || advance;
   assign take       = req_tvalid && req_tready;
   assign valid_in   = take || (valid_ff && !advance);

   // out-of-range operand fields count as zero
   always_comb begin
      op_in.hours   = req_tdata[4:0];
      op_in.minutes = req_tdata[10:5];
      op_in.seconds = req_tdata[16:11];
      if (op_in.hours > MAX_HOUR) op_in.hours = '0;
      if (op_in.minutes > MAX_MINSEC) op_in.minutes = '0;
      if (op_in.seconds > MAX_MINSEC) op_in.seconds = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         mode_ff <= req_tuser;
         op_ff   <= op_in;
      end
   end

   assign stage.valid   = valid_ff;
   assign stage.mode    = mode_ff;
   assign stage.operand = op_ff;

endmodule

FILE: rtl/tod_calc.sv
`timescale 1ns / 1ps
module tod_calc import tod_pkg::*; (
   input  hms_type    prior,
   input  mode_type   mode,
   input  hms_type    operand,
   output result_type result
);

   hms_type sum_t, dif_t, up_t, down_t, fwd_gap, back_gap, next_t;
   logic    less;

   assign sum_t    = hms_add(prior, operand);
   assign dif_t    = hms_sub(prior, operand);
   assign up_t     = hms_add(prior, ONE_SECOND);
   assign down_t   = hms_sub(prior, ONE_SECOND);
   assign fwd_gap  = hms_sub(operand, prior);
   assign back_gap = hms_sub(prior, operand);
   assign less     = (prior < operand);

   always_comb begin
      case (mode)
         MODE_LOAD:      next_t = operand;
         MODE_TICK_UP:   next_t = up_t;
         MODE_TICK_DOWN: next_t = down_t;
         MODE_ADD:       next_t = sum_t;
         MODE_SUB:       next_t = dif_t;
         default:        next_t = prior;
      endcase
   end

   assign result.cur      = next_t;
   assign result.total    = TOTAL_W'(next_t.hours) * SECS_PER_HOUR
                          + TOTAL_W'(next_t.minutes) * SECS_PER_MIN
                          + TOTAL_W'(next_t.seconds);
   assign result.is_less  = less;
   assign result.is_equal = (prior == operand);
   assign result.gap      = less ? fwd_gap : back_gap;

endmodule

FILE: rtl/time_of_day_alu_unit.sv
`timescale 1ns / 1ps
// an accepted request passes the input and result registers to rsp_tvalid
// throughput: one item per cycle without rsp_tready stalls, set by both registers
// the time register updates as each item leaves the input register
// reset (synchronous, active high) clears the time to 00:00:00 and empties
// both register stages
module time_of_day_alu_unit import tod_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [2:0]  req_tuser,   // mode
   input  logic [23:0] req_tdata,   // op_hours, op_minutes, op_seconds, zero fill
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // cur_hours, cur_minutes, cur_seconds, total_seconds, is_less, is_equal,
   // gap_hours, gap_minutes, gap_seconds, zero fill
   output logic [55:0] rsp_tdata
);

   stage_type  stage;
   result_type result;
   result_type rsp_ff;
   hms_type    time_ff;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       advance;

   assign advance      = stage.valid && (!rsp_valid_ff || rsp_tready);
   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp_tready);

   tod_req_stage u_req_stage (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .advance    (advance),
      .stage      (stage)
   );

   tod_calc u_calc (
      .prior   (time_ff),
      .mode    (stage.mode),
      .operand (stage.operand),
      .result  (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         time_ff      <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            time_ff <= result.cur;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'd0,
                        rsp_ff.gap.seconds, rsp_ff.gap.minutes, rsp_ff.gap.hours,
                        rsp_ff.is_equal, rsp_ff.is_less, rsp_ff.total,
                        rsp_ff.cur.seconds, rsp_ff.cur.minutes, rsp_ff.cur.hours};

endmodule

FILE: tb/sv/tb_time_of_day_alu_unit.sv
`timescale 1ns / 1ps
module tb_time_of_day_alu_unit;
   import tod_pkg::*;

   localparam int unsigned SECS_PER_DAY = 24 * 60 * 60;
   localparam int unsigned RANDOM_PER_MIX = 375;
   localparam int unsigned DRAIN_CYCLES = 10;

   typedef struct packed {
      mode_type mode;
      hms_type  operand;
   } tod_request_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [2:0]  req_tuser = '0;   // mode
   logic [23:0] req_tdata = '0;   // op_hours, op_minutes, op_seconds, zero fill
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   // cur_hours, cur_minutes, cur_seconds, total_seconds, is_less, is_equal,
   // gap_hours, gap_minutes, gap_seconds, zero fill
   logic [55:0] rsp_tdata;

   tod_request_type request_queue[$];
   result_type      expected_results[$];
   hms_type         time_now = '0;
   hms_type         plan_time = '0;
   tod_request_type in_flight = '0;
   int unsigned     sender_idle_pct = 0;
   int unsigned     receiver_stall_pct = 0;
   int unsigned     error_count = 0;
   int unsigned     result_count = 0;
   int unsigned     clipped_operands = 0;
   int unsigned     mode_hits[8] = '{default: 0};

   time_of_day_alu_unit uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #1 clock = ~clock;

   function automatic hms_type seconds_to_hms(int unsigned t);
      hms_type r;
      t         = t % SECS_PER_DAY;
      r.hours   = 5'(t / 3600);
      r.minutes = 6'((t % 3600) / 60);
      r.seconds = 6'(t % 60);
      return r;
   endfunction

   // next time is the cur field of the returned result
   function automatic result_type tod_step(hms_type now, mode_type mode, hms_type raw);
      hms_type     opnd;
      int unsigned prior;
      int unsigned opnd_s;
      int unsigned next_s;
      int unsigned gap_s;
      result_type  r;
      opnd.hours   = (raw.hours > MAX_HOUR) ? '0 : raw.hours;
      opnd.minutes = (raw.minutes > MAX_MINSEC) ? '0 : raw.minutes;
      opnd.seconds = (raw.seconds > MAX_MINSEC) ? '0 : raw.seconds;
      prior  = (now.hours * 3600 + now.minutes * 60 + now.seconds) % SECS_PER_DAY;
      opnd_s = opnd.hours * 3600 + opnd.minutes * 60 + opnd.seconds;
      gap_s  = (prior <= opnd_s) ? opnd_s - prior : prior - opnd_s;
      case (mode)
         MODE_LOAD:      next_s = opnd_s;
         MODE_TICK_UP:   next_s = (prior + 1) % SECS_PER_DAY;
         MODE_TICK_DOWN: next_s = (prior + SECS_PER_DAY - 1) % SECS_PER_DAY;
         MODE_ADD:       next_s = (prior + opnd_s) % SECS_PER_DAY;
         MODE_SUB:       next_s = (prior + SECS_PER_DAY - opnd_s) % SECS_PER_DAY;
         default:        next_s = prior;
      endcase
      r.cur      = seconds_to_hms(next_s);
      r.total    = 17'(next_s);
      r.is_less  = (prior < opnd_s);
      r.is_equal = (prior == opnd_s);
      r.gap      = seconds_to_hms(gap_s);
      return r;
   endfunction

   task automatic queue_request(mode_type mode, int unsigned h, int unsigned m,
                                int unsigned s);
      tod_request_type req;
      result_type      res;
      req.mode            = mode;
      req.operand.hours   = 5'(h);
      req.operand.minutes = 6'(m);
      req.operand.seconds = 6'(s);
      res       = tod_step(plan_time, req.mode, req.operand);
      plan_time = res.cur;
      request_queue.push_back(req);
   endtask

   task automatic queue_random_request();
      int unsigned pick;
      int unsigned t;
      pick = $urandom_range(99);
      if (pick < 12) begin
         // operand at or right next to the time it will meet
         t = plan_time.hours * 3600 + plan_time.minutes * 60 + plan_time.seconds;
         t = (t + SECS_PER_DAY + $urandom_range(2) - 1) % SECS_PER_DAY;
         queue_request(3'($urandom_range(7)), t / 3600, (t % 3600) / 60, t % 60);
      end else if (pick < 80) begin
         queue_request(3'($urandom_range(7)), $urandom_range(23), $urandom_range(59),
                       $urandom_range(59));
      end else if (pick < 88) begin
         queue_request(3'($urandom_range(7)), $urandom_range(1) * 23,
                       $urandom_range(1) * 59, $urandom_range(1) * 59);
      end else begin
         queue_request(3'($urandom_range(7)), $urandom_range(31), $urandom_range(63),
                       $urandom_range(63));
      end
   endtask

   task automatic compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         error_count++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin : drive_proc
      result_type res;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            res      = tod_step(time_now, in_flight.mode, in_flight.operand);
            time_now = res.cur;
            expected_results.push_back(res);
            mode_hits[in_flight.mode]++;
            if (in_flight.operand.hours > MAX_HOUR || in_flight.operand.minutes > MAX_MINSEC
                || in_flight.operand.seconds > MAX_MINSEC) begin
               clipped_operands++;
            end
         end
         if (!req_tvalid || req_tready) begin
            if (request_queue.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
               in_flight  = request_queue.pop_front();
               req_tvalid <= 1'b1;
               req_tuser  <= in_flight.mode;
               req_tdata  <= {7'd0, in_flight.operand.seconds, in_flight.operand.minutes,
                              in_flight.operand.hours};
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : check_proc
      result_type got;
      result_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.cur.hours   = rsp_tdata[4:0];
            got.cur.minutes = rsp_tdata[10:5];
            got.cur.seconds = rsp_tdata[16:11];
            got.total       = rsp_tdata[33:17];
            got.is_less     = rsp_tdata[34];
            got.is_equal    = rsp_tdata[35];
            got.gap.hours   = rsp_tdata[40:36];
            got.gap.minutes = rsp_tdata[46:41];
            got.gap.seconds = rsp_tdata[52:47];
            if (expected_results.size() == 0) begin
               error_count++;
               $display("%0t: unexpected transaction, expected none, actual %h", $time,
                        rsp_tdata);
            end else begin
               want = expected_results.pop_front();
               result_count++;
               compare_field("cur_hours", want.cur.hours, got.cur.hours);
               compare_field("cur_minutes", want.cur.minutes, got.cur.minutes);
               compare_field("cur_seconds", want.cur.seconds, got.cur.seconds);
               compare_field("total_seconds", want.total, got.total);
               compare_field("is_less", want.is_less, got.is_less);
               compare_field("is_equal", want.is_equal, got.is_equal);
               compare_field("gap_hours", want.gap.hours, got.gap.hours);
               compare_field("gap_minutes", want.gap.minutes, got.gap.minutes);
               compare_field("gap_seconds", want.gap.seconds, got.gap.seconds);
            end
         end
         rsp_tready <= ($urandom_range(99) >= receiver_stall_pct);
      end
   end

   initial begin : main_proc
      int unsigned idle_mix[4];
      int unsigned stall_mix[4];
      idle_mix  = '{0, 77, 0, 20};
      stall_mix = '{0, 0, 77, 20};

      // wraps, clipping, unused modes and comparisons, starting from reset
      queue_request(MODE_HOLD, 0, 0, 0);
      queue_request(MODE_TICK_DOWN, 0, 0, 0);
      queue_request(MODE_TICK_UP, 5, 5, 5);
      queue_request(MODE_LOAD, 23, 59, 59);
      queue_request(MODE_TICK_UP, 23, 59, 59);
      queue_request(MODE_LOAD, 31, 63, 63);
      queue_request(MODE_LOAD, 24, 60, 60);
      queue_request(MODE_LOAD, 12, 30, 45);
      queue_request(MODE_HOLD, 12, 30, 45);
      queue_request(MODE_HOLD, 12, 30, 46);
      queue_request(MODE_HOLD, 12, 30, 44);
      queue_request(3'd6, 23, 59, 59);
      queue_request(3'd7, 0, 0, 0);
      queue_request(MODE_ADD, 23, 59, 59);
      queue_request(MODE_ADD, 0, 0, 0);
      queue_request(MODE_SUB, 23, 59, 59);
      queue_request(MODE_SUB, 12, 30, 46);
      queue_request(MODE_ADD, 31, 63, 63);
      queue_request(MODE_SUB, 0, 0, 1);
      queue_request(MODE_ADD, 0, 0, 2);
      queue_request(MODE_TICK_DOWN, 0, 0, 0);
      queue_request(MODE_LOAD, 0, 59, 60);
      queue_request(MODE_HOLD, 23, 0, 0);
      queue_request(MODE_ADD, 11, 29, 59);

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      for (int phase = 0; phase < 4; phase++) begin
         sender_idle_pct    = idle_mix[phase];
         receiver_stall_pct = stall_mix[phase];
         repeat (RANDOM_PER_MIX) queue_random_request();
         while (request_queue.size() > 0) @(posedge clock);
      end

      while (req_tvalid) @(posedge clock);
      while (expected_results.size() > 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("checked %0d results under four idle and stall mixes, %0d with clipped operands",
               result_count, clipped_operands);
      $display("mode counts 0..7: %0d %0d %0d %0d %0d %0d %0d %0d", mode_hits[0],
               mode_hits[1], mode_hits[2], mode_hits[3], mode_hits[4], mode_hits[5],
               mode_hits[6], mode_hits[7]);
      if (error_count == 0 && expected_results.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   initial begin : watchdog_proc
      #1000000;
      $display("simulation failed");
      $finish;
   end

endmodule
